>>> rtl/per_iface_token_bucket_queue_assert.svh
// Assertion macros for the token bucket queue.
`ifndef PER_IFACE_TOKEN_BUCKET_QUEUE_ASSERT_SVH
`define PER_IFACE_TOKEN_BUCKET_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PTBQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PTBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ptbq_pkg.sv
`default_nettype none
package ptbq_pkg;

    localparam int DEF_NUM_IFACES  = 16;
    localparam int DEF_QUEUE_SLOTS = 16;

    localparam logic [19:0] CAP_RST   = 20'd5000;
    localparam logic [19:0] RATE_RST  = 20'd1000;
    localparam logic [19:0] LIMIT_RST = 20'd262144;

    // ceil(2^50 / 1000), exact quotient for any product below 2^30
    localparam logic [40:0] RCP      = 41'd1125899906843;
    localparam logic [20:0] RCP_LO   = RCP[20:0];
    localparam logic [19:0] RCP_HI   = RCP[40:21];
    localparam logic [9:0]  MS_PER_S = 10'd1000;

    typedef enum logic [1:0] {
        ACT_SEND  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_PURGE = 2'd2,
        ACT_FLUSH = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        VRD_SEND  = 2'd0,
        VRD_QUEUE = 2'd1,
        VRD_LIMIT = 2'd2,
        VRD_FULL  = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_RATE     = 2'd1,
        CFG_LIMIT    = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEND_WAIT,
        S_SEND_OUT,
        S_WALK,
        S_WALK_WAIT,
        S_DRAIN_RD,
        S_DRAIN_OUT,
        S_SUM
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  iface;
        logic [15:0] length;
        logic [15:0] handle;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  verdict;
        logic [15:0] out_handle;
        logic [3:0]  out_iface;
        logic [15:0] out_length;
        logic [15:0] drop_total;
        logic        queue_nonempty;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  iface;
        logic [15:0] length;
        logic [15:0] handle;
    } t_desc;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic        start;
        logic [15:0] length;
        logic [31:0] now_ms;
    } t_bkt_req;

    typedef struct packed {
        logic done;
        logic pass;
    } t_bkt_rsp;

endpackage
`default_nettype wire

>>> rtl/ptbq_cell.sv
`default_nettype none
module ptbq_cell (
    input  wire logic              i_clk,
    input  wire ptbq_pkg::t_cell_ctl i_ctl,
    input  wire ptbq_pkg::t_desc   i_next,
    input  wire ptbq_pkg::t_desc   i_new,
    output      ptbq_pkg::t_desc   o_desc
);
    import ptbq_pkg::*;

    t_desc r_desc;

    // load wins: it is the tail of the queue taking a new or kept descriptor
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_desc <= i_new;
        end else if (i_ctl.shift) begin
            r_desc <= i_next;
        end
    end

    assign o_desc = r_desc;
endmodule
`default_nettype wire

>>> rtl/ptbq_bucket.sv
`default_nettype none
module ptbq_bucket #(
    parameter int NUM_IFACES = ptbq_pkg::DEF_NUM_IFACES,
    parameter int BW         = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ptbq_pkg::t_bkt_req i_req,
    input  wire logic [BW-1:0]     i_index,
    input  wire logic [19:0]       i_capacity,
    input  wire logic [19:0]       i_rate,
    output      ptbq_pkg::t_bkt_rsp o_rsp
);
    import ptbq_pkg::*;

    logic [19:0] mem_tok  [NUM_IFACES];
    logic [31:0] mem_last [NUM_IFACES];
    logic [NUM_IFACES-1:0] r_valid;

    logic [4:0]    r_stg;
    logic [BW-1:0] r_idx;
    logic [15:0]   r_len;
    logic [31:0]   r_now;
    logic          r_rd_vld;
    logic [19:0]   r_rd_tok;
    logic [31:0]   r_rd_last;
    logic [31:0]   r_elapsed;
    logic [19:0]   r_tok;
    logic [51:0]   r_prod;
    logic [30:0]   r_lim;
    logic          r_big;
    logic [50:0]   r_pl;
    logic [49:0]   r_ph;
    logic [19:0]   r_q;

    logic [70:0] w_sum;
    logic [20:0] w_add;
    logic [20:0] w_tok;
    logic        w_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg   <= '0;
            r_valid <= '0;
        end else begin
            r_stg <= {r_stg[3:0], i_req.start};
            if (r_stg[4]) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_idx     <= i_index;
            r_len     <= i_req.length;
            r_now     <= i_req.now_ms;
            r_rd_vld  <= r_valid[i_index];
            r_rd_tok  <= mem_tok[i_index];
            r_rd_last <= mem_last[i_index];
        end
        if (r_stg[4]) begin
            mem_tok[r_idx]  <= w_pass ? w_tok[19:0] - 20'(r_len) : w_tok[19:0];
            mem_last[r_idx] <= r_now;
        end
    end

    // a fresh bucket starts full with zero elapsed time
    always_ff @(posedge i_clk) begin
        if (!r_rd_vld) begin
            r_tok     <= i_capacity;
            r_elapsed <= '0;
        end else begin
            r_tok     <= r_rd_tok;
            r_elapsed <= (r_now >= r_rd_last) ? r_now - r_rd_last : '0;
        end
        r_prod <= r_elapsed * 52'(i_rate);
        r_lim  <= (31'(i_capacity) + 31'd1) * 31'(MS_PER_S);
        // refill exceeds capacity exactly when the product reaches (cap+1)*1000
        r_big  <= (r_prod >= 52'(r_lim));
        r_pl   <= r_prod[29:0] * 51'(RCP_LO);
        r_ph   <= r_prod[29:0] * 50'(RCP_HI);
        r_q    <= w_sum[69:50];
    end

    assign w_sum  = {r_ph, 21'd0} + 71'(r_pl);
    assign w_add  = r_big ? 21'(i_capacity) : 21'(r_tok) + 21'(r_q);
    assign w_tok  = (w_add > 21'(i_capacity)) ? 21'(i_capacity) : w_add;
    assign w_pass = (w_tok >= 21'(r_len));

    assign o_rsp = '{done: r_stg[4], pass: w_pass};
endmodule
`default_nettype wire

>>> rtl/per_iface_token_bucket_queue.sv
// Per-interface token bucket limiter with a shared descriptor queue of QUEUE_SLOTS cells.
// One request is worked at a time; o_in_stall is high until its last result sits in the
// output register. A send request goes through the bucket refill pipeline (multiply,
// reciprocal divide by 1000, clamp). A process tick walks the queue head through that
// pipeline, one queued descriptor at a time, since neighbors may share a bucket; purge and
// flush step the queue without the pipeline. Released packets are buffered during the walk
// and then drained one by one through a read and an output state, followed by one summary
// result, so every result carries the final queue_nonempty. No clearing pass after reset.
`default_nettype none
module per_iface_token_bucket_queue #(
    parameter int NUM_IFACES  = ptbq_pkg::DEF_NUM_IFACES,
    parameter int QUEUE_SLOTS = ptbq_pkg::DEF_QUEUE_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire ptbq_pkg::t_in_item i_in_data,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      ptbq_pkg::t_out_item o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [19:0]        i_cfg_data
);
    import ptbq_pkg::*;

    localparam int BW  = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
    localparam int QCW = $clog2(QUEUE_SLOTS + 1);
    localparam int QAW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

    t_state r_state, n_state;
    t_in_item r_in;
    logic [19:0] r_cap, r_rate, r_limit;
    logic [QCW-1:0] r_cnt, n_cnt, r_left, n_left, r_wptr, n_wptr, r_rptr, n_rptr;
    logic [20:0] r_qbytes, n_qbytes;
    logic [15:0] r_drops, n_drops;
    logic [1:0]  r_verdict, n_verdict;
    t_out_item r_out, n_out;
    logic r_ovalid, n_ovalid;

    t_desc mem_rel [QUEUE_SLOTS];
    t_desc r_rel_data;

    t_desc w_cell [QUEUE_SLOTS];
    t_cell_ctl w_ctl [QUEUE_SLOTS];
    t_desc w_new;
    logic [BW-1:0] w_btab [16];
    logic [BW-1:0] w_bidx;
    t_bkt_req w_breq;
    t_bkt_rsp w_brsp;
    t_desc w_head, w_in_desc;
    logic w_accept, w_ofree, w_step, w_rel, w_rem, w_append;
    logic [QCW-1:0] w_tail;

    // iface modulo NUM_IFACES, worked out at elaboration
    for (genvar v = 0; v < 16; v++) begin : g_btab
        assign w_btab[v] = BW'(v % NUM_IFACES);
    end

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_ofree   = !r_ovalid || !i_out_stall;
    assign w_head    = w_cell[0];
    assign w_tail    = r_cnt - QCW'(1);
    assign w_in_desc = '{iface: r_in.iface, length: r_in.length, handle: r_in.handle};

    ptbq_bucket #(.NUM_IFACES(NUM_IFACES), .BW(BW)) u_bucket (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_breq),
        .i_index    (w_bidx),
        .i_capacity (r_cap),
        .i_rate     (r_rate),
        .o_rsp      (w_brsp)
    );

    assign w_new = w_append ? w_in_desc : w_head;

    for (genvar i = 0; i < QUEUE_SLOTS; i++) begin : g_cell
        assign w_ctl[i] = '{shift: w_step && (QCW'(i) < w_tail),
                            load: (w_append && (QCW'(i) == r_cnt))
                                  || (w_step && !w_rem && (QCW'(i) == w_tail))};
        ptbq_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl[i]),
            .i_next (w_cell[(i + 1 < QUEUE_SLOTS) ? i + 1 : i]),
            .i_new  (w_new),
            .o_desc (w_cell[i])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_wptr    = r_wptr;
        n_rptr    = r_rptr;
        n_qbytes  = r_qbytes;
        n_drops   = r_drops;
        n_verdict = r_verdict;
        n_out     = r_out;
        n_ovalid  = r_ovalid && i_out_stall;
        w_breq    = '0;
        w_bidx    = w_btab[w_head.iface];
        w_step    = 1'b0;
        w_rel     = 1'b0;
        w_rem     = 1'b0;
        w_append  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_left = r_cnt;
                    n_wptr = '0;
                    n_rptr = '0;
                    if (i_in_data.action == ACT_SEND) begin
                        w_breq = '{start: 1'b1, length: i_in_data.length,
                                   now_ms: i_in_data.now_ms};
                        w_bidx = w_btab[i_in_data.iface];
                        n_state = S_SEND_WAIT;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_SEND_WAIT: begin
                if (w_brsp.done) begin
                    n_state = S_SEND_OUT;
                    if (w_brsp.pass) begin
                        n_verdict = VRD_SEND;
                    end else if (r_qbytes + 21'(r_in.length) > 21'(r_limit)) begin
                        n_verdict = VRD_LIMIT;
                        if (r_drops != 16'hFFFF) n_drops = r_drops + 16'd1;
                    end else if (r_cnt >= QCW'(QUEUE_SLOTS)) begin
                        n_verdict = VRD_FULL;
                        if (r_drops != 16'hFFFF) n_drops = r_drops + 16'd1;
                    end else begin
                        w_append  = 1'b1;
                        n_cnt     = r_cnt + QCW'(1);
                        n_qbytes  = r_qbytes + 21'(r_in.length);
                        n_verdict = VRD_QUEUE;
                    end
                end
            end
            S_SEND_OUT: begin
                if (w_ofree) begin
                    n_out = '{kind: KIND_VERDICT, verdict: r_verdict,
                              out_handle: r_in.handle, out_iface: r_in.iface,
                              out_length: r_in.length, drop_total: r_drops,
                              queue_nonempty: (r_cnt != '0), last: 1'b1};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WALK: begin
                if (r_left == '0) begin
                    if (r_cnt == '0) n_qbytes = '0;
                    n_state = (r_wptr == '0) ? S_SUM : S_DRAIN_RD;
                end else if (r_in.action == ACT_TICK) begin
                    w_breq  = '{start: 1'b1, length: w_head.length, now_ms: r_in.now_ms};
                    n_state = S_WALK_WAIT;
                end else begin
                    w_step = 1'b1;
                    w_rel  = (r_in.action == ACT_FLUSH);
                    w_rem  = (r_in.action == ACT_FLUSH) || (w_head.iface == r_in.iface);
                end
            end
            S_WALK_WAIT: begin
                if (w_brsp.done) begin
                    w_step  = 1'b1;
                    w_rel   = w_brsp.pass;
                    w_rem   = w_brsp.pass;
                    n_state = S_WALK;
                end
            end
            S_DRAIN_RD: begin
                n_state = S_DRAIN_OUT;
            end
            S_DRAIN_OUT: begin
                if (w_ofree) begin
                    n_out = '{kind: KIND_RELEASE, verdict: VRD_SEND,
                              out_handle: r_rel_data.handle, out_iface: r_rel_data.iface,
                              out_length: r_rel_data.length, drop_total: '0,
                              queue_nonempty: (r_cnt != '0), last: 1'b0};
                    n_ovalid = 1'b1;
                    n_rptr   = r_rptr + QCW'(1);
                    n_state  = (r_rptr + QCW'(1) == r_wptr) ? S_SUM : S_DRAIN_RD;
                end
            end
            S_SUM: begin
                if (w_ofree) begin
                    n_out = '{kind: KIND_SUMMARY, verdict: VRD_SEND, out_handle: '0,
                              out_iface: '0, out_length: '0, drop_total: r_drops,
                              queue_nonempty: (r_cnt != '0), last: 1'b1};
                    n_ovalid = 1'b1;
                    if (r_in.action == ACT_TICK) n_drops = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // head leaves the front; a kept one goes back in at the tail
        if (w_step) begin
            n_left = r_left - QCW'(1);
            if (w_rel) n_wptr = r_wptr + QCW'(1);
            if (w_rem) begin
                n_cnt    = r_cnt - QCW'(1);
                n_qbytes = (r_qbytes >= 21'(w_head.length))
                         ? r_qbytes - 21'(w_head.length) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_left   <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_qbytes <= '0;
            r_drops  <= '0;
            r_ovalid <= 1'b0;
            r_cap    <= CAP_RST;
            r_rate   <= RATE_RST;
            r_limit  <= LIMIT_RST;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_left   <= n_left;
            r_wptr   <= n_wptr;
            r_rptr   <= n_rptr;
            r_qbytes <= n_qbytes;
            r_drops  <= n_drops;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_cap   <= i_cfg_data;
                    CFG_RATE:     r_rate  <= i_cfg_data;
                    CFG_LIMIT:    r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_in <= i_in_data;
        r_verdict <= n_verdict;
        r_out     <= n_out;
        if (w_step && w_rel) mem_rel[r_wptr[QAW-1:0]] <= w_head;
        if (r_state == S_DRAIN_RD) r_rel_data <= mem_rel[r_rptr[QAW-1:0]];
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`include "per_iface_token_bucket_queue_assert.svh"

    `PTBQ_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= QCW'(QUEUE_SLOTS), "queue count overflow")
    `PTBQ_ASSERT_NOW(a_rel_order, 1'b1, r_rptr <= r_wptr, "release drain passed fill")
    `PTBQ_ASSERT_NOW(a_idle_bytes, (r_state == S_IDLE) && (r_cnt == '0), r_qbytes == '0, "bytes held with empty queue")
    `PTBQ_ASSERT_NEXT(a_walk_left, (r_state == S_WALK) && (r_left != '0), r_left <= r_cnt, "walk beyond queue")

endmodule
`default_nettype wire

>>> sim/tb_per_iface_token_bucket_queue.sv
`default_nettype none
module tb_per_iface_token_bucket_queue;
    import ptbq_pkg::*;

    localparam int N_IFACES   = 16;
    localparam int N_SLOTS    = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int RX_HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;

    per_iface_token_bucket_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the limiter state
    logic [19:0] cap_q, rate_q, limit_q;
    logic        bkt_valid [N_IFACES];
    logic [31:0] bkt_tokens [N_IFACES];
    logic [31:0] bkt_time [N_IFACES];
    t_desc       desc_q [$];
    logic [31:0] bytes_q;
    logic [15:0] drops_q;

    t_out_item   expected_results [$];
    int          errors = 0;
    bit          rand_idle = 1'b1;
    bit          hold_rx = 1'b0;
    int          idle_cycles = 0;
    logic [31:0] clock_ms = 0;

    function automatic bit bucket_allows(logic [3:0] ifc, logic [15:0] len, logic [31:0] now);
        int unsigned b;
        logic [31:0] elapsed;
        logic [63:0] refill;
        logic [31:0] tok;
        b = ifc % N_IFACES;
        if (!bkt_valid[b]) begin
            bkt_valid[b] = 1'b1;
            bkt_tokens[b] = 32'(cap_q);
            bkt_time[b] = now;
        end
        elapsed = (now >= bkt_time[b]) ? now - bkt_time[b] : 32'd0;
        refill = 64'(elapsed) * 64'(rate_q) / 64'd1000;
        tok = bkt_tokens[b];
        if (refill > 64'(cap_q)) tok = 32'(cap_q);
        else tok = tok + refill[31:0];
        if (tok > cap_q) tok = 32'(cap_q);
        bkt_time[b] = now;
        if (tok >= len) begin
            bkt_tokens[b] = tok - len;
            return 1'b1;
        end
        bkt_tokens[b] = tok;
        return 1'b0;
    endfunction

    function automatic void predict_results(t_in_item it);
        t_out_item r [$];
        t_out_item o;
        t_desc     kept [$];
        bit        rel, rem;
        r = {};
        if (it.action == ACT_SEND) begin
            o = '0;
            o.kind = KIND_VERDICT;
            if (bucket_allows(it.iface, it.length, it.now_ms)) o.verdict = VRD_SEND;
            else if (bytes_q + it.length > limit_q) begin
                o.verdict = VRD_LIMIT;
                if (drops_q != 16'hFFFF) drops_q++;
            end else if (desc_q.size() >= N_SLOTS) begin
                o.verdict = VRD_FULL;
                if (drops_q != 16'hFFFF) drops_q++;
            end else begin
                desc_q.push_back(t_desc'{iface: it.iface, length: it.length,
                                         handle: it.handle});
                bytes_q += it.length;
                o.verdict = VRD_QUEUE;
            end
            o.out_handle = it.handle;
            o.out_iface = it.iface;
            o.out_length = it.length;
            o.drop_total = drops_q;
            r.push_back(o);
        end else begin
            kept = {};
            foreach (desc_q[i]) begin
                if (it.action == ACT_TICK) begin
                    rel = bucket_allows(desc_q[i].iface, desc_q[i].length, it.now_ms);
                    rem = rel;
                end else if (it.action == ACT_PURGE) begin
                    rel = 1'b0;
                    rem = (desc_q[i].iface == it.iface);
                end else begin
                    rel = 1'b1;
                    rem = 1'b1;
                end
                if (rel) begin
                    o = '0;
                    o.kind = KIND_RELEASE;
                    o.out_handle = desc_q[i].handle;
                    o.out_iface = desc_q[i].iface;
                    o.out_length = desc_q[i].length;
                    r.push_back(o);
                end
                if (rem) bytes_q -= (bytes_q >= desc_q[i].length) ? desc_q[i].length : bytes_q;
                else kept.push_back(desc_q[i]);
            end
            desc_q = kept;
            if (desc_q.size() == 0) bytes_q = 0;
            o = '0;
            o.kind = KIND_SUMMARY;
            o.drop_total = drops_q;
            r.push_back(o);
            if (it.action == ACT_TICK) drops_q = 0;
        end
        foreach (r[k]) begin
            r[k].queue_nonempty = (desc_q.size() != 0);
            r[k].last = (k == r.size() - 1);
            expected_results.push_back(r[k]);
        end
    endfunction

    // receiver: random stall bursts, one long counted hold on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_out_stall <= 1'b1;
                for (n = 0; n < RX_HOLD_CYCLES; n++) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_rx = 1'b0;
            end else if (rand_idle && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 18);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, o_out_data);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_out_data !== e) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, e, o_out_data);
                    errors++;
                end
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[per_iface_token_bucket_queue] ERROR");
            $finish;
        end
    end

    // valid stays up after the accepting edge; the next call or the caller drops it
    task automatic send_request(t_in_item it);
        if (rand_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_results(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [19:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_CAPACITY: cap_q = val;
            CFG_RATE:     rate_q = val;
            default:      limit_q = val;
        endcase
    endtask

    function automatic t_in_item make_item(t_action act, logic [3:0] ifc,
                                           logic [15:0] len, logic [31:0] now);
        t_in_item it;
        it.action = act;
        it.iface = ifc;
        it.length = len;
        it.handle = 16'($urandom);
        it.now_ms = now;
        return it;
    endfunction

    // time mostly moves forward, sometimes jumps back or to a random value
    function automatic logic [31:0] next_ms();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return clock_ms - $urandom_range(0, 3000);
            default: begin
                clock_ms += $urandom_range(0, 4000);
                return clock_ms;
            end
        endcase
    endfunction

    task automatic test_directed();
        send_request(make_item(ACT_SEND, 4'd0, 16'd0, 32'd0));
        send_request(make_item(ACT_SEND, 4'd0, 16'd5000, 32'd0));
        send_request(make_item(ACT_SEND, 4'd0, 16'hFFFF, 32'd10));
        send_request(make_item(ACT_SEND, 4'd15, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_item(ACT_SEND, 4'd0, 16'd4000, 32'd5));
        send_request(make_item(ACT_TICK, 4'd0, 16'd0, 32'd2000));
        send_request(make_item(ACT_TICK, 4'd0, 16'd0, 32'd100));
        send_request(make_item(ACT_PURGE, 4'd15, 16'd0, 32'd0));
        send_request(make_item(ACT_SEND, 4'd3, 16'd6000, 32'd0));
        send_request(make_item(ACT_SEND, 4'd7, 16'd6000, 32'd0));
        send_request(make_item(ACT_FLUSH, 4'd0, 16'd0, 32'd0));
        send_request(make_item(ACT_PURGE, 4'd3, 16'd0, 32'd0));
        send_request(make_item(ACT_TICK, 4'hA, 16'hFFFF, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    // fill the queue past its slot count and past the byte limit
    task automatic test_queue_limits();
        write_reg(CFG_CAPACITY, 20'd0);
        write_reg(CFG_LIMIT, 20'd200000);
        for (int i = 0; i < 20; i++)
            send_request(make_item(ACT_SEND, 4'(i), 16'(1 + $urandom_range(0, 15000)), 32'd0));
        send_request(make_item(ACT_PURGE, 4'd2, 16'd0, 32'd0));
        send_request(make_item(ACT_TICK, 4'd0, 16'd0, 32'd0));
        send_request(make_item(ACT_FLUSH, 4'd0, 16'd0, 32'd0));
        wait_drained();
        write_reg(CFG_LIMIT, 20'd0);
        send_request(make_item(ACT_SEND, 4'd1, 16'd0, 32'd0));
        send_request(make_item(ACT_SEND, 4'd1, 16'd1, 32'd0));
        send_request(make_item(ACT_FLUSH, 4'd0, 16'd0, 32'd0));
        wait_drained();
    endtask

    task automatic random_phase(int count, int max_len, int ifc_hi);
        t_in_item it;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 19);
            it.action = (sel < 12) ? ACT_SEND : (sel < 17) ? ACT_TICK :
                        (sel < 19) ? ACT_PURGE : ACT_FLUSH;
            it.iface = 4'($urandom_range(0, ifc_hi));
            it.length = ($urandom_range(0, 15) == 0) ? 16'($urandom) :
                        16'($urandom_range(0, max_len));
            it.handle = 16'($urandom);
            it.now_ms = next_ms();
            send_request(it);
        end
    endtask

    task automatic test_random_settings();
        write_reg(CFG_CAPACITY, 20'd8000);
        write_reg(CFG_RATE, 20'd2000);
        write_reg(CFG_LIMIT, 20'd40000);
        random_phase(80, 6000, 15);
        wait_drained();
        write_reg(CFG_CAPACITY, 20'hFFFFF);
        write_reg(CFG_RATE, 20'hFFFFF);
        write_reg(CFG_LIMIT, 20'hFFFFF);
        random_phase(50, 65535, 15);
        wait_drained();
        write_reg(CFG_CAPACITY, 20'd3000);
        write_reg(CFG_RATE, 20'd0);
        write_reg(CFG_LIMIT, 20'd20000);
        random_phase(50, 4000, 3);
        wait_drained();
        write_reg(CFG_RATE, 20'd500);
        random_phase(40, 2000, 5);
        wait_drained();
    endtask

    // receiver holds off while requests keep coming, then sender waits for drain
    task automatic test_backpressure();
        hold_rx = 1'b1;
        random_phase(12, 3000, 15);
        wait_drained();
    endtask

    task automatic test_steady();
        rand_idle = 1'b0;
        random_phase(50, 3000, 15);
    endtask

    initial begin
        cap_q = CAP_RST;
        rate_q = RATE_RST;
        limit_q = LIMIT_RST;
        foreach (bkt_valid[b]) bkt_valid[b] = 1'b0;
        bytes_q = 0;
        drops_q = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_queue_limits();
        test_random_settings();
        test_backpressure();
        test_steady();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("[per_iface_token_bucket_queue] OK");
        end else begin
            $display("[per_iface_token_bucket_queue] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
